// ----- src/spi_nor_command_sequencer_macros.svh -----
// assertion macros for the spi nor command sequencer
`ifndef SPI_NOR_COMMAND_SEQUENCER_MACROS_SVH
`define SPI_NOR_COMMAND_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SNC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SNC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/snc_pkg.sv -----
// types and constants of the spi nor command sequencer
`timescale 1ns / 1ps
package snc_pkg;
	localparam int unsigned MAX_RES = 8;
	localparam int unsigned PAGE_LEFT_W = 13;
	localparam logic [17:0] TICK_MAX = 18'h3FFFF;

	localparam logic [1:0] OP_REQ = 2'd0;
	localparam logic [1:0] OP_FLASH = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_WBYTE = 2'd3;

	localparam logic [2:0] K_READ = 3'd0;
	localparam logic [2:0] K_WRITE = 3'd1;
	localparam logic [2:0] K_ER4K = 3'd2;
	localparam logic [2:0] K_ER64K = 3'd4;
	localparam logic [2:0] K_CHIP = 3'd5;

	localparam logic [2:0] A_SEND = 3'd0;
	localparam logic [2:0] A_CLKIN = 3'd1;
	localparam logic [2:0] A_DESEL = 3'd2;
	localparam logic [2:0] A_HOST = 3'd3;
	localparam logic [2:0] A_ASK = 3'd4;
	localparam logic [2:0] A_DONE = 3'd5;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_TIMEOUT = 3'd2;
	localparam logic [2:0] ST_NOWEL = 3'd3;
	localparam logic [2:0] ST_REJECT = 3'd4;

	localparam logic [7:0] CMD_WREN = 8'h06;
	localparam logic [7:0] CMD_RDSR = 8'h05;
	localparam logic [7:0] CMD_PP = 8'h02;
	localparam logic [7:0] CMD_SE4K = 8'h20;
	localparam logic [7:0] CMD_BE32K = 8'h52;
	localparam logic [7:0] CMD_BE64K = 8'hD8;
	localparam logic [7:0] CMD_CE = 8'hC7;
	localparam logic [7:0] CMD_READ = 8'h03;

	localparam logic [7:0] CAP_LO = 8'h14;
	localparam logic [7:0] CAP_HI = 8'h19;

	typedef enum logic [2:0] {
		PH_IDLE, PH_POLL, PH_WEL, PH_READ, PH_WDATA
	} phase_t;

	typedef enum logic [2:0] {
		R_NONE, R_READ_PRE, R_ERASE_PRE, R_PAGE, R_FINAL
	} resume_t;

	typedef struct packed {
		phase_t phase;
		resume_t resume;
		logic [2:0] kind;
		logic [24:0] addr;
		logic [15:0] bytes_left;
		logic [PAGE_LEFT_W-1:0] page_left;
		logic [17:0] elapsed;
		logic [17:0] limit;
	} seq_state_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] data;
		logic [2:0] status;
	} result_t;

	typedef struct packed {
		logic present;
		logic [25:0] cap;
		logic [15:0] rw_to;
		logic [15:0] erase_to;
		logic [15:0] chip_to;
	} seq_cfg_t;
endpackage

// ----- src/snc_step.sv -----
// next-state and result list for one item
`timescale 1ns / 1ps
module snc_step import snc_pkg::*; #(
	parameter int unsigned PAGE_BYTES = 256
) (
	input seq_state_t st,
	input seq_cfg_t cfg,
	input logic [1:0] op,
	input logic [2:0] kind,
	input logic [24:0] start_address,
	input logic [15:0] byte_count,
	input logic [7:0] in_byte,
	output seq_state_t nx,
	output result_t lst [MAX_RES],
	output logic [3:0] n
);
	localparam int unsigned PW = $clog2(PAGE_BYTES);

	logic ok;
	logic [PAGE_LEFT_W-1:0] chunk;
	logic [1:0] ei;

	always_comb begin
		nx = st;
		n = 4'd0;
		ok = 1'b0;
		chunk = '0;
		ei = 2'd0;
		for (int i = 0; i < MAX_RES; i++) lst[i] = '0;
		case (op)
			OP_REQ: begin
				if (st.phase != PH_IDLE) begin
					lst[n[2:0]] = '{A_DONE, 8'h00, ST_REJECT}; n = n + 4'd1;
				end else begin
					ok = cfg.present && (kind <= K_CHIP);
					if (ok && kind <= K_WRITE && (byte_count == 16'd0 ||
						({2'b00, start_address} + {11'd0, byte_count}) > {1'b0, cfg.cap}))
						ok = 1'b0;
					if (ok && kind >= K_ER4K && kind <= K_ER64K &&
						{1'b0, start_address} >= cfg.cap)
						ok = 1'b0;
					if (!ok) begin
						lst[n[2:0]] = '{A_DONE, 8'h00, ST_INVALID}; n = n + 4'd1;
						nx.phase = PH_IDLE;
						nx.resume = R_NONE;
					end else begin
						nx.kind = kind;
						nx.addr = start_address;
						nx.bytes_left = byte_count;
						nx.page_left = '0;
						if (kind == K_WRITE) begin
							lst[n[2:0]] = '{A_SEND, CMD_WREN, ST_OK}; n = n + 4'd1;
							lst[n[2:0]] = '{A_DESEL, 8'h00, ST_OK}; n = n + 4'd1;
							lst[n[2:0]] = '{A_SEND, CMD_RDSR, ST_OK}; n = n + 4'd1;
							lst[n[2:0]] = '{A_CLKIN, 8'h00, ST_OK}; n = n + 4'd1;
							nx.phase = PH_WEL;
						end else begin
							nx.elapsed = '0;
							nx.limit = {2'b00, cfg.rw_to};
							nx.resume = (kind == K_READ) ? R_READ_PRE : R_ERASE_PRE;
							nx.phase = PH_POLL;
							lst[n[2:0]] = '{A_SEND, CMD_RDSR, ST_OK}; n = n + 4'd1;
							lst[n[2:0]] = '{A_CLKIN, 8'h00, ST_OK}; n = n + 4'd1;
						end
					end
				end
			end
			OP_FLASH: begin
				if (st.phase == PH_POLL) begin
					lst[n[2:0]] = '{A_DESEL, 8'h00, ST_OK}; n = n + 4'd1;
					if (in_byte[0]) begin
						if (st.elapsed > st.limit) begin
							lst[n[2:0]] = '{A_DONE, 8'h00, ST_TIMEOUT}; n = n + 4'd1;
							nx.phase = PH_IDLE;
							nx.resume = R_NONE;
						end else begin
							lst[n[2:0]] = '{A_SEND, CMD_RDSR, ST_OK}; n = n + 4'd1;
							lst[n[2:0]] = '{A_CLKIN, 8'h00, ST_OK}; n = n + 4'd1;
						end
					end else if (st.resume == R_READ_PRE) begin
						lst[n[2:0]] = '{A_SEND, CMD_READ, ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_SEND, st.addr[23:16], ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_SEND, st.addr[15:8], ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_SEND, st.addr[7:0], ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_CLKIN, 8'h00, ST_OK}; n = n + 4'd1;
						nx.phase = PH_READ;
					end else if (st.resume == R_ERASE_PRE ||
						(st.resume == R_PAGE && st.bytes_left != 16'd0)) begin
						lst[n[2:0]] = '{A_SEND, CMD_WREN, ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_DESEL, 8'h00, ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_SEND, CMD_RDSR, ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_CLKIN, 8'h00, ST_OK}; n = n + 4'd1;
						nx.phase = PH_WEL;
					end else begin
						lst[n[2:0]] = '{A_DONE, 8'h00, ST_OK}; n = n + 4'd1;
						nx.phase = PH_IDLE;
						nx.resume = R_NONE;
					end
				end else if (st.phase == PH_WEL) begin
					lst[n[2:0]] = '{A_DESEL, 8'h00, ST_OK}; n = n + 4'd1;
					if (!in_byte[1]) begin
						lst[n[2:0]] = '{A_DONE, 8'h00, ST_NOWEL}; n = n + 4'd1;
						nx.phase = PH_IDLE;
						nx.resume = R_NONE;
					end else if (st.kind == K_WRITE) begin
						chunk = PAGE_LEFT_W'(PAGE_BYTES) - PAGE_LEFT_W'(st.addr[PW-1:0]);
						if ({{(16 - PAGE_LEFT_W){1'b0}}, chunk} > st.bytes_left)
							chunk = st.bytes_left[PAGE_LEFT_W-1:0];
						nx.page_left = chunk;
						lst[n[2:0]] = '{A_SEND, CMD_PP, ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_SEND, st.addr[23:16], ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_SEND, st.addr[15:8], ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_SEND, st.addr[7:0], ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_ASK, 8'h00, ST_OK}; n = n + 4'd1;
						nx.phase = PH_WDATA;
					end else begin
						if (st.kind >= K_ER4K && st.kind <= K_ER64K) begin
							ei = 2'(st.kind - K_ER4K);
							lst[n[2:0]] = '{A_SEND, (ei == 2'd0) ? CMD_SE4K :
								(ei == 2'd1) ? CMD_BE32K : CMD_BE64K, ST_OK};
							n = n + 4'd1;
							lst[n[2:0]] = '{A_SEND, st.addr[23:16], ST_OK}; n = n + 4'd1;
							lst[n[2:0]] = '{A_SEND, st.addr[15:8], ST_OK}; n = n + 4'd1;
							lst[n[2:0]] = '{A_SEND, st.addr[7:0], ST_OK}; n = n + 4'd1;
							nx.limit = {2'b00, cfg.erase_to} << ei;
						end else begin
							lst[n[2:0]] = '{A_SEND, CMD_CE, ST_OK}; n = n + 4'd1;
							nx.limit = {2'b00, cfg.chip_to};
						end
						lst[n[2:0]] = '{A_DESEL, 8'h00, ST_OK}; n = n + 4'd1;
						nx.elapsed = '0;
						nx.resume = R_FINAL;
						nx.phase = PH_POLL;
						lst[n[2:0]] = '{A_SEND, CMD_RDSR, ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_CLKIN, 8'h00, ST_OK}; n = n + 4'd1;
					end
				end else if (st.phase == PH_READ) begin
					lst[n[2:0]] = '{A_HOST, in_byte, ST_OK}; n = n + 4'd1;
					if (st.bytes_left != 16'd0) nx.bytes_left = st.bytes_left - 16'd1;
					if (nx.bytes_left != 16'd0) begin
						lst[n[2:0]] = '{A_CLKIN, 8'h00, ST_OK}; n = n + 4'd1;
					end else begin
						lst[n[2:0]] = '{A_DESEL, 8'h00, ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_DONE, 8'h00, ST_OK}; n = n + 4'd1;
						nx.phase = PH_IDLE;
						nx.resume = R_NONE;
					end
				end
			end
			OP_TICK: begin
				if (st.phase == PH_POLL && st.elapsed < TICK_MAX)
					nx.elapsed = st.elapsed + 18'd1;
			end
			default: begin
				if (st.phase == PH_WDATA) begin
					lst[n[2:0]] = '{A_SEND, in_byte, ST_OK}; n = n + 4'd1;
					if (st.page_left != '0) nx.page_left = st.page_left - PAGE_LEFT_W'(1);
					if (st.bytes_left != 16'd0) nx.bytes_left = st.bytes_left - 16'd1;
					nx.addr = st.addr + 25'd1;
					if (nx.page_left != '0) begin
						lst[n[2:0]] = '{A_ASK, 8'h00, ST_OK}; n = n + 4'd1;
					end else begin
						lst[n[2:0]] = '{A_DESEL, 8'h00, ST_OK}; n = n + 4'd1;
						nx.elapsed = '0;
						nx.limit = {2'b00, cfg.rw_to};
						nx.resume = R_PAGE;
						nx.phase = PH_POLL;
						lst[n[2:0]] = '{A_SEND, CMD_RDSR, ST_OK}; n = n + 4'd1;
						lst[n[2:0]] = '{A_CLKIN, 8'h00, ST_OK}; n = n + 4'd1;
					end
				end
			end
		endcase
	end
endmodule

// ----- src/spi_nor_command_sequencer.sv -----
// top level of the spi nor command sequencer
// usage:
// s_axis carries one item per handshake: tuser holds the op (request, flash
// byte, ms tick, host write byte), tdata the request fields and the byte.
// m_axis returns the actions for the spi link and the host, one per handshake;
// tlast marks the final action caused by one input item.
// cfg_we writes register cfg_index (0 present, 1 capacity code, 2 rw
// timeout, 3 erase timeout, 4 chip erase timeout) with cfg_data.
// flow: an item is registered, then its whole action list (0 to 8
// entries) is formed combinationally and loaded into the output list
// once that list is free; the first action is then presented from the
// output list.
// the output list drains one action per cycle while m_axis_tready is high;
// the next item waits in the input register until the last action of the
// list is taken, and items making no action (ticks, ignored bytes) pass one per cycle while the output list is empty.
// reset clears the sequencer to idle and the registers to their defaults.
// when m_axis stalls the output list holds; one further item waits in the
// input register and s_axis_tready drops until the list can be reloaded.
// PAGE_BYTES must be a power of two.
`timescale 1ns / 1ps
`include "spi_nor_command_sequencer_macros.svh"
module spi_nor_command_sequencer import snc_pkg::*; #(
	parameter int unsigned PAGE_BYTES = 256
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// request_kind[2:0], start_address[27:3], byte_count[43:28], in_byte[51:44]
	input logic [55:0] s_axis_tdata,
	// op[1:0]
	input logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// action[2:0], out_byte[10:3], status[13:11]
	output logic [15:0] m_axis_tdata,
	output logic m_axis_tlast,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);
	logic present_q;
	logic [7:0] cap_code_q;
	logic [15:0] rw_to_q, erase_to_q, chip_to_q;
	seq_cfg_t cfg;

	logic valid_s1;
	logic [55:0] data_s1;
	logic [1:0] op_s1;

	seq_state_t st_q, nx;
	result_t lst [MAX_RES];
	logic [3:0] n;
	result_t buf_q [MAX_RES];
	logic [3:0] rem_q;
	logic [2:0] idx_q;
	logic free, load, out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			cap_code_q <= 8'd0;
			rw_to_q <= 16'd100;
			erase_to_q <= 16'd3000;
			chip_to_q <= 16'd60000;
		end else if (cfg_we) begin
			case (cfg_index)
				3'd0: present_q <= cfg_data[0];
				3'd1: cap_code_q <= cfg_data[7:0];
				3'd2: rw_to_q <= cfg_data;
				3'd3: erase_to_q <= cfg_data;
				3'd4: chip_to_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.present = present_q;
		cfg.rw_to = rw_to_q;
		cfg.erase_to = erase_to_q;
		cfg.chip_to = chip_to_q;
		if (cap_code_q >= CAP_LO && cap_code_q <= CAP_HI)
			cfg.cap = 26'd1 << cap_code_q[4:0];
		else
			cfg.cap = 26'd1 << 23;
	end

	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign free = (rem_q == 4'd0) || (rem_q == 4'd1 && m_axis_tready);
	assign load = valid_s1 && free;
	assign s_axis_tready = !valid_s1 || load;

	snc_step #(.PAGE_BYTES(PAGE_BYTES)) u_step (
		.st(st_q),
		.cfg(cfg),
		.op(op_s1),
		.kind(data_s1[2:0]),
		.start_address(data_s1[27:3]),
		.byte_count(data_s1[43:28]),
		.in_byte(data_s1[51:44]),
		.nx(nx),
		.lst(lst),
		.n(n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q <= '{PH_IDLE, R_NONE, 3'd0, 25'd0, 16'd0, '0, 18'd0, 18'd0};
			rem_q <= 4'd0;
			idx_q <= 3'd0;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (load) begin
				st_q <= nx;
				rem_q <= n;
				idx_q <= 3'd0;
			end else if (out_acc) begin
				rem_q <= rem_q - 4'd1;
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			op_s1 <= s_axis_tuser;
		end
		if (load) buf_q <= lst;
	end

	assign m_axis_tvalid = rem_q != 4'd0;
	assign m_axis_tdata = {2'b00, buf_q[idx_q].status, buf_q[idx_q].data,
		buf_q[idx_q].action};
	assign m_axis_tlast = rem_q == 4'd1;

	`SNC_ASSERT_NOW(a_list_bound, rem_q != 4'd0, ({1'b0, idx_q} + rem_q) <= 4'd8, "list overrun")
	`SNC_ASSERT_NOW(a_idle_resume, st_q.phase == PH_IDLE, st_q.resume == R_NONE, "stale resume")
	`SNC_ASSERT_NOW(a_wdata_page, st_q.phase == PH_WDATA, st_q.page_left != '0, "empty page")
	`SNC_ASSERT_NEXT(a_load_pops, load && n != 4'd0, !valid_s1 || m_axis_tvalid, "lost list")
endmodule
